// File: design/scsba_pkg.sv
// Shared types, constants and helper functions of the size class slot allocator.
package scsba_pkg;

    localparam int CLASSES = 8;
    localparam int SLOTS   = 64;
    localparam int CLASS_W = (CLASSES > 1) ? $clog2(CLASSES) : 1;
    localparam int NREGS   = 8;
    localparam int MAP_W   = 64;

    typedef enum logic [2:0] {
        FN_PUT    = 3'd0,
        FN_TAKE   = 3'd1,
        FN_FREE   = 3'd2,
        FN_REMOTE = 3'd3,
        FN_RETIRE = 3'd4,
        FN_QUERY  = 3'd5,
        FN_CLEAR  = 3'd6
    } func_t;

    typedef enum logic [1:0] {
        MODE_LOCAL   = 2'd0,
        MODE_REMOTE  = 2'd1,
        MODE_RETIRED = 2'd2
    } mode_t;

    typedef struct packed {
        logic [2:0] func;
        logic [2:0] size_cls;
        logic [5:0] slot;
    } in_item_t;

    typedef struct packed {
        logic             ok;
        logic [5:0]       taken_slot;
        logic [1:0]       class_state;
        logic [MAP_W-1:0] free_map;
        logic [MAP_W-1:0] alloc_map;
        logic [MAP_W-1:0] pending_map;
        logic [7:0]       touched_map;
    } out_item_t;

    typedef struct packed {
        logic [MAP_W-1:0] free_map;
        logic [MAP_W-1:0] alloc_map;
        logic [MAP_W-1:0] pending_map;
        mode_t            mode;
    } class_entry_t;

    // Index of the lowest set bit, zero when no bit is set.
    function automatic logic [5:0] lowest_set(input logic [MAP_W-1:0] v);
        logic [5:0] idx;
        idx = '0;
        for (int i = MAP_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = 6'(i);
            end
        end
        return idx;
    endfunction

endpackage

// File: design/scsba_if.sv
// Valid/ready channel interfaces for the allocator's requests and responses.
interface scsba_req_if;
    logic                valid;
    logic                ready;
    scsba_pkg::in_item_t data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface scsba_rsp_if;
    logic                 valid;
    logic                 ready;
    scsba_pkg::out_item_t data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: design/size_class_slot_bitmap_allocator_core.sv
// Top level of the size class slot bitmap allocator with its class entry memory.
// A request accepted in IDLE reads the class entry memory; EXEC computes the response,
// which is registered. No new request is taken until EXEC has finished: the read of the
// class entry memory is followed by the state that modifies and writes the entry back.
// A pending response does not block the next request; only a second finished result does.
// Reset: rst_n is asynchronous and active low; it empties all classes at once through the
// per-entry valid bits and sets every slot count register to 64.
module size_class_slot_bitmap_allocator_core (
    input  logic                         clk,
    input  logic                         rst_n,
    scsba_req_if.sink                    req,
    scsba_rsp_if.source                  rsp,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [6:0]                   cfg_data
);
    import scsba_pkg::*;

    // Two-state sequencer: IDLE takes a request and issues the memory read,
    // EXEC holds the read data, computes the new entry and the response.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    in_item_t         item_reg;
    class_entry_t     mem [CLASSES];
    class_entry_t     rd_entry_reg;
    logic             rd_valid_reg;
    logic [CLASSES-1:0] entry_valid_reg, entry_valid_next;
    logic [7:0]       touched_reg, touched_next;
    logic [6:0]       slots_reg [NREGS];
    logic             rsp_valid_reg, rsp_valid_next;
    out_item_t        rsp_data_reg;

    logic             req_fire;
    logic             exec_go;
    logic [CLASS_W-1:0] cls_idx;
    logic             in_range;
    logic             slot_valid;
    logic [MAP_W-1:0] slot_bit;
    logic [MAP_W-1:0] take_bit;
    logic [5:0]       take_idx;
    class_entry_t     cur_entry;
    class_entry_t     new_entry;
    logic             op_ok;
    logic             op_write;
    logic             op_clear;
    logic [5:0]       taken;
    out_item_t        rsp_data_next;

    assign req_fire = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign exec_go  = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp.ready);

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // Configuration registers: the slot count of each class.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NREGS; i++)
            begin
                slots_reg[i] <= 7'd64;
            end
        end
        else if (cfg_we)
        begin
            slots_reg[cfg_index] <= cfg_data;
        end
    end

    // Class entry memory, with a registered read issued when a request transaction
    // is accepted. The write back in EXEC always lands before the next read.
    assign cls_idx = item_reg.size_cls[CLASS_W-1:0];

    always_ff @(posedge clk)
    begin
        if (op_write)
        begin
            mem[cls_idx] <= new_entry;
        end
        if (req_fire)
        begin
            rd_entry_reg <= mem[req.data.size_cls[CLASS_W-1:0]];
        end
    end

    // An entry whose valid bit is clear has never been written since the last
    // reset or clear all, and reads as an empty local class.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else if (req_fire)
        begin
            rd_valid_reg <= entry_valid_reg[req.data.size_cls[CLASS_W-1:0]];
        end
    end

    assign cur_entry = rd_valid_reg ? rd_entry_reg : '0;

    // Operation decode and entry update.
    assign in_range   = ({1'b0, item_reg.size_cls} < 4'(CLASSES));
    assign slot_valid = in_range
                        && ({1'b0, item_reg.slot} < slots_reg[item_reg.size_cls])
                        && ({1'b0, item_reg.slot} < 7'(SLOTS));
    assign slot_bit   = MAP_W'(1) << item_reg.slot;
    assign take_idx   = lowest_set(cur_entry.free_map);
    assign take_bit   = MAP_W'(1) << take_idx;

    always_comb
    begin
        new_entry = cur_entry;
        op_ok     = 1'b0;
        op_clear  = 1'b0;
        taken     = '0;
        unique case (item_reg.func)
            FN_PUT:
            begin
                if (slot_valid && cur_entry.mode == MODE_LOCAL
                    && ((cur_entry.free_map | cur_entry.alloc_map
                         | cur_entry.pending_map) & slot_bit) == '0)
                begin
                    new_entry.free_map = cur_entry.free_map | slot_bit;
                    op_ok = 1'b1;
                end
            end
            FN_TAKE:
            begin
                if (in_range && cur_entry.mode == MODE_LOCAL && cur_entry.free_map != '0)
                begin
                    taken = take_idx;
                    new_entry.free_map  = cur_entry.free_map & ~take_bit;
                    new_entry.alloc_map = cur_entry.alloc_map | take_bit;
                    op_ok = 1'b1;
                end
            end
            FN_FREE:
            begin
                if (slot_valid && cur_entry.mode == MODE_LOCAL
                    && (cur_entry.alloc_map & slot_bit) != '0
                    && ((cur_entry.free_map | cur_entry.pending_map) & slot_bit) == '0)
                begin
                    new_entry.alloc_map = cur_entry.alloc_map & ~slot_bit;
                    new_entry.free_map  = cur_entry.free_map | slot_bit;
                    op_ok = 1'b1;
                end
            end
            FN_REMOTE:
            begin
                if (slot_valid && cur_entry.mode != MODE_RETIRED
                    && (cur_entry.pending_map & slot_bit) == '0)
                begin
                    new_entry.pending_map = cur_entry.pending_map | slot_bit;
                    new_entry.free_map    = cur_entry.free_map & ~slot_bit;
                    new_entry.alloc_map   = cur_entry.alloc_map & ~slot_bit;
                    new_entry.mode        = MODE_REMOTE;
                    op_ok = 1'b1;
                end
            end
            FN_RETIRE:
            begin
                if (in_range)
                begin
                    new_entry = '0;
                    new_entry.mode = MODE_RETIRED;
                    op_ok = 1'b1;
                end
            end
            FN_QUERY:
            begin
                op_ok = in_range;
            end
            FN_CLEAR:
            begin
                new_entry = '0;
                op_clear  = 1'b1;
                op_ok     = 1'b1;
            end
            default:
            begin
                op_ok = 1'b0;
            end
        endcase
    end

    // Only state-changing operations that succeed write the entry back.
    assign op_write = exec_go && op_ok && !op_clear
                      && (item_reg.func != FN_QUERY);

    always_comb
    begin
        entry_valid_next = entry_valid_reg;
        touched_next     = touched_reg;
        if (exec_go)
        begin
            if (op_clear)
            begin
                entry_valid_next = '0;
                touched_next     = '0;
            end
            else
            begin
                if (op_write)
                begin
                    entry_valid_next[cls_idx] = 1'b1;
                end
                if (op_ok && item_reg.func == FN_PUT)
                begin
                    touched_next[item_reg.size_cls] = 1'b1;
                end
            end
        end
    end

    // Response assembly: an out of range class reports zero maps and state.
    always_comb
    begin
        rsp_data_next.ok          = op_ok;
        rsp_data_next.taken_slot  = taken;
        rsp_data_next.touched_map = touched_next;
        if (in_range)
        begin
            rsp_data_next.class_state = new_entry.mode;
            rsp_data_next.free_map    = new_entry.free_map;
            rsp_data_next.alloc_map   = new_entry.alloc_map;
            rsp_data_next.pending_map = new_entry.pending_map;
        end
        else
        begin
            rsp_data_next.class_state = '0;
            rsp_data_next.free_map    = '0;
            rsp_data_next.alloc_map   = '0;
            rsp_data_next.pending_map = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            rsp_valid_reg   <= 1'b0;
            entry_valid_reg <= '0;
            touched_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            rsp_valid_reg   <= rsp_valid_next;
            entry_valid_reg <= entry_valid_next;
            touched_reg     <= touched_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            item_reg <= req.data;
        end
        if (exec_go)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    // A slot is never in two maps of the same class at once.
    a_maps_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> ((rsp_data_reg.free_map & rsp_data_reg.alloc_map) == '0
                           && (rsp_data_reg.free_map & rsp_data_reg.pending_map) == '0
                           && (rsp_data_reg.alloc_map & rsp_data_reg.pending_map) == '0))
        else $error("slot present in more than one map");

    // A retired class holds no slots.
    a_retired_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_data_reg.class_state == MODE_RETIRED)
        |-> (rsp_data_reg.free_map == '0 && rsp_data_reg.alloc_map == '0
             && rsp_data_reg.pending_map == '0))
        else $error("retired class reports slots");

    // A successful take moves the handed out slot into the allocated map.
    a_take_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_go && item_reg.func == FN_TAKE && op_ok)
        |=> (rsp_data_reg.alloc_map[rsp_data_reg.taken_slot]
             && !rsp_data_reg.free_map[rsp_data_reg.taken_slot]))
        else $error("taken slot not recorded as allocated");

    // Clear all leaves no class marked as touched.
    a_clear_touched: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_go && op_clear) |=> (touched_reg == '0 && entry_valid_reg == '0))
        else $error("clear all left state behind");

endmodule
